[hdl/ccrag_pkg.sv]
// Shared types and constants for the center-crop resize address generator.
package ccrag_pkg;

   localparam int unsigned DIM_W      = 11;
   localparam int unsigned CHAN_W     = 3;
   localparam int unsigned ADDR_W     = 22;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned SCALE_W    = DIM_W + FRAC_W;
   localparam int unsigned CROP_W     = 10;
   localparam int unsigned PROD_W     = SCALE_W + DIM_W;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 22;

   localparam logic [CHAN_W-1:0] RAW_PLANES = 3'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RAW   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_OUT   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DST_SMALL = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RAW_SMALL = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_RAW_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RAW_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RAW_CHANNELS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RAW_SIZE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HEIGHT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_CAPACITY = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_BGR_ORDER    = 3'd7;

   typedef struct packed {
      logic [DIM_W-1:0]  raw_width;
      logic [DIM_W-1:0]  raw_height;
      logic [CHAN_W-1:0] raw_channels;
      logic [ADDR_W-1:0] raw_size_bytes;
      logic [DIM_W-1:0]  out_width;
      logic [DIM_W-1:0]  out_height;
      logic [ADDR_W-1:0] out_capacity_bytes;
      logic              bgr_order;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      raw_width:          11'd320,
      raw_height:         11'd240,
      raw_channels:       3'd3,
      raw_size_bytes:     22'd230400,
      out_width:          11'd160,
      out_height:         11'd160,
      out_capacity_bytes: 22'd76800,
      bgr_order:          1'b1
   };

   typedef enum logic [4:0] {
      OP_NOP,
      OP_CHK_OUT,
      OP_CHK_RAW,
      OP_CHK_END,
      OP_ERR_OUT,
      OP_DIV_W,
      OP_DIV_H,
      OP_SCALE,
      OP_CROP_X,
      OP_CROP_Y,
      OP_FRAME_START,
      OP_PIX_X,
      OP_PIX_Y,
      OP_PIX_S,
      OP_PIX_SR,
      OP_PIX_P,
      OP_PIX_OUT
   } dp_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                running;
      logic                div_busy;
   } dp_stat_type;

endpackage

[hdl/ccrag_div.sv]
// Restoring divider that produces one quotient bit per cycle for the scale ratio.
module ccrag_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ccrag_pkg::SCALE_W-1:0]   dividend,
   input  logic [ccrag_pkg::DIM_W-1:0]     divisor,
   output logic                            busy,
   output logic [ccrag_pkg::SCALE_W-1:0]   quotient
);

   localparam int unsigned QW  = ccrag_pkg::SCALE_W;
   localparam int unsigned DW  = ccrag_pkg::DIM_W;
   localparam int unsigned CNT_W = $clog2(QW + 1);

   logic [QW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DW:0]      trial;
   logic [DW:0]      diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[QW-1]};
      diff    = trial - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[hdl/ccrag_dpath.sv]
// Datapath: configuration checks, scale and crop registers, pixel counters and result register.
module ccrag_dpath #(
   parameter int unsigned MAX_DIM = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ccrag_pkg::cfg_type                cfg,
   input  ccrag_pkg::dp_op_type              op,
   output ccrag_pkg::dp_stat_type            stat,
   output logic [ccrag_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ccrag_pkg::ADDR_W-1:0]      rsp_src_addr_byte0,
   output logic [ccrag_pkg::ADDR_W-1:0]      rsp_src_addr_byte1,
   output logic [ccrag_pkg::ADDR_W-1:0]      rsp_src_addr_byte2,
   output logic [ccrag_pkg::ADDR_W-1:0]      rsp_dst_offset,
   output logic                              rsp_last
);

   localparam int unsigned DW   = ccrag_pkg::DIM_W;
   localparam int unsigned AW   = ccrag_pkg::ADDR_W;
   localparam int unsigned SW   = ccrag_pkg::SCALE_W;
   localparam int unsigned FW   = ccrag_pkg::FRAC_W;
   localparam int unsigned CW   = ccrag_pkg::CROP_W;
   localparam int unsigned PW   = ccrag_pkg::PROD_W;
   localparam int unsigned SUM_W = PW - FW + 1;
   localparam int unsigned A3_W = AW + 2;

   function automatic logic [AW-1:0] clamp_coord(input logic [CW-1:0] org,
                                                 input logic [PW-1:0] p,
                                                 input logic [DW-1:0] dim);
      logic [SUM_W-1:0] full;
      full = SUM_W'(org) + SUM_W'(p[PW-1:FW]);
      if (dim != '0 && full >= SUM_W'(dim)) begin
         return AW'(dim - 1'b1);
      end
      return AW'(full);
   endfunction

   function automatic logic [CW-1:0] crop_origin(input logic [DW-1:0] dim,
                                                 input logic [DW-1:0] used);
      logic [DW-1:0] diff;
      diff = dim - used;
      return CW'(diff >> 1);
   endfunction

   function automatic logic [A3_W-1:0] times3(input logic [AW-1:0] v);
      return A3_W'(v) + A3_W'({v, 1'b0});
   endfunction

   logic [PW-1:0] prod_ff, prod_in;
   logic          out_fit_ff, out_fit_in;
   logic          raw_fit_ff, raw_fit_in;
   logic [SW-1:0] sw_ff, sw_in;
   logic [SW-1:0] scale_ff, scale_in;
   logic [CW-1:0] crop_x0_ff, crop_x0_in;
   logic [CW-1:0] crop_y0_ff, crop_y0_in;
   logic [DW-1:0] col_ff, col_in;
   logic [DW-1:0] row_ff, row_in;
   logic          running_ff, running_in;
   logic [AW-1:0] sx_ff, sx_in;
   logic [AW-1:0] sy_ff, sy_in;
   logic [AW-1:0] s_ff, s_in;
   logic [AW-1:0] dst_ff, dst_in;

   logic [ccrag_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [AW-1:0] byte0_ff, byte0_in;
   logic [AW-1:0] byte1_ff, byte1_in;
   logic [AW-1:0] byte2_ff, byte2_in;
   logic [AW-1:0] dofs_ff, dofs_in;
   logic          last_ff, last_in;

   logic [SW-1:0] mul_a;
   logic [DW-1:0] mul_b;
   logic          mul_en;
   logic          div_start;
   logic [SW-1:0] div_dividend;
   logic [DW-1:0] div_divisor;
   logic          div_busy;
   logic [SW-1:0] div_quo;
   logic [ccrag_pkg::STATUS_W-1:0] cfg_status;
   logic [AW-1:0] plane;
   logic [AW-1:0] addr_mid;
   logic [AW-1:0] addr_far;
   logic [AW-1:0] dst_base;
   logic          col_end;
   logic          row_end;

   ccrag_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   always_comb begin
      if (cfg.raw_channels != ccrag_pkg::RAW_PLANES || cfg.raw_width == '0 ||
          cfg.raw_height == '0) begin
         cfg_status = ccrag_pkg::STATUS_BAD_RAW;
      end else if (cfg.out_width == '0 || cfg.out_height == '0 ||
                   32'(cfg.out_width) > MAX_DIM || 32'(cfg.out_height) > MAX_DIM) begin
         cfg_status = ccrag_pkg::STATUS_BAD_OUT;
      end else if (!out_fit_ff) begin
         cfg_status = ccrag_pkg::STATUS_DST_SMALL;
      end else if (!raw_fit_ff) begin
         cfg_status = ccrag_pkg::STATUS_RAW_SMALL;
      end else begin
         cfg_status = ccrag_pkg::STATUS_OK;
      end
   end

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (op)
         ccrag_pkg::OP_CHK_OUT: begin
            mul_a = SW'(cfg.out_width);
            mul_b = cfg.out_height;
         end
         ccrag_pkg::OP_CHK_RAW, ccrag_pkg::OP_PIX_P: begin
            mul_a = SW'(cfg.raw_width);
            mul_b = cfg.raw_height;
         end
         ccrag_pkg::OP_CROP_X: begin
            mul_a = scale_ff;
            mul_b = cfg.out_width;
         end
         ccrag_pkg::OP_CROP_Y: begin
            mul_a = scale_ff;
            mul_b = cfg.out_height;
         end
         ccrag_pkg::OP_PIX_X: begin
            mul_a = scale_ff;
            mul_b = col_ff;
         end
         ccrag_pkg::OP_PIX_Y: begin
            mul_a = scale_ff;
            mul_b = row_ff;
         end
         ccrag_pkg::OP_PIX_S: begin
            mul_a = SW'(cfg.out_width);
            mul_b = row_ff;
         end
         ccrag_pkg::OP_PIX_SR: begin
            mul_a = SW'(sy_ff);
            mul_b = cfg.raw_width;
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign prod_in = mul_en ? (PW'(mul_a) * PW'(mul_b)) : prod_ff;

   assign div_start    = (op == ccrag_pkg::OP_DIV_W) || (op == ccrag_pkg::OP_DIV_H);
   assign div_dividend = (op == ccrag_pkg::OP_DIV_W) ? {cfg.raw_width, {FW{1'b0}}}
                                                     : {cfg.raw_height, {FW{1'b0}}};
   assign div_divisor  = (op == ccrag_pkg::OP_DIV_W) ? cfg.out_width : cfg.out_height;

   assign plane    = prod_ff[AW-1:0];
   assign addr_mid = plane + s_ff;
   assign addr_far = {plane[AW-2:0], 1'b0} + s_ff;
   assign dst_base = prod_ff[AW-1:0] + AW'(col_ff);
   assign col_end  = ({1'b0, col_ff} + 1'b1) >= {1'b0, cfg.out_width};
   assign row_end  = ({1'b0, row_ff} + 1'b1) >= {1'b0, cfg.out_height};

   always_comb begin
      out_fit_in = out_fit_ff;
      raw_fit_in = raw_fit_ff;
      sw_in      = sw_ff;
      scale_in   = scale_ff;
      crop_x0_in = crop_x0_ff;
      crop_y0_in = crop_y0_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      running_in = running_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      s_in       = s_ff;
      dst_in     = dst_ff;
      status_in  = status_ff;
      byte0_in   = byte0_ff;
      byte1_in   = byte1_ff;
      byte2_in   = byte2_ff;
      dofs_in    = dofs_ff;
      last_in    = last_ff;
      case (op)
         ccrag_pkg::OP_CHK_RAW: begin
            out_fit_in = A3_W'(cfg.out_capacity_bytes) >= times3(prod_ff[AW-1:0]);
         end
         ccrag_pkg::OP_CHK_END: begin
            raw_fit_in = A3_W'(cfg.raw_size_bytes) >= times3(prod_ff[AW-1:0]);
         end
         ccrag_pkg::OP_ERR_OUT: begin
            running_in = 1'b0;
            status_in  = cfg_status;
            byte0_in   = '0;
            byte1_in   = '0;
            byte2_in   = '0;
            dofs_in    = '0;
            last_in    = 1'b1;
         end
         ccrag_pkg::OP_DIV_W: begin
            running_in = 1'b0;
         end
         ccrag_pkg::OP_DIV_H: begin
            sw_in = div_quo;
         end
         ccrag_pkg::OP_SCALE: begin
            scale_in = (div_quo < sw_ff) ? div_quo : sw_ff;
         end
         ccrag_pkg::OP_CROP_Y: begin
            crop_x0_in = crop_origin(cfg.raw_width, prod_ff[SW-1:FW]);
         end
         ccrag_pkg::OP_FRAME_START: begin
            crop_y0_in = crop_origin(cfg.raw_height, prod_ff[SW-1:FW]);
            col_in     = '0;
            row_in     = '0;
            running_in = 1'b1;
         end
         ccrag_pkg::OP_PIX_Y: begin
            sx_in = clamp_coord(crop_x0_ff, prod_ff, cfg.raw_width);
         end
         ccrag_pkg::OP_PIX_S: begin
            sy_in = clamp_coord(crop_y0_ff, prod_ff, cfg.raw_height);
         end
         ccrag_pkg::OP_PIX_SR: begin
            dst_in = AW'(times3(dst_base));
         end
         ccrag_pkg::OP_PIX_P: begin
            s_in = prod_ff[AW-1:0] + sx_ff;
         end
         ccrag_pkg::OP_PIX_OUT: begin
            status_in = ccrag_pkg::STATUS_OK;
            byte0_in  = cfg.bgr_order ? s_ff : addr_far;
            byte1_in  = addr_mid;
            byte2_in  = cfg.bgr_order ? addr_far : s_ff;
            dofs_in   = dst_ff;
            last_in   = 1'b0;
            if (col_end) begin
               col_in = '0;
               if (row_end) begin
                  row_in     = '0;
                  running_in = 1'b0;
                  last_in    = 1'b1;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
         scale_ff   <= '0;
         crop_x0_ff <= '0;
         crop_y0_ff <= '0;
      end else begin
         running_ff <= running_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         scale_ff   <= scale_in;
         crop_x0_ff <= crop_x0_in;
         crop_y0_ff <= crop_y0_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      out_fit_ff <= out_fit_in;
      raw_fit_ff <= raw_fit_in;
      sw_ff      <= sw_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      s_ff       <= s_in;
      dst_ff     <= dst_in;
      status_ff  <= status_in;
      byte0_ff   <= byte0_in;
      byte1_ff   <= byte1_in;
      byte2_ff   <= byte2_in;
      dofs_ff    <= dofs_in;
      last_ff    <= last_in;
   end

   assign stat.status   = cfg_status;
   assign stat.running  = running_ff;
   assign stat.div_busy = div_busy;

   assign rsp_status         = status_ff;
   assign rsp_src_addr_byte0 = byte0_ff;
   assign rsp_src_addr_byte1 = byte1_ff;
   assign rsp_src_addr_byte2 = byte2_ff;
   assign rsp_dst_offset     = dofs_ff;
   assign rsp_last           = last_ff;

endmodule

[hdl/ccrag_ctrl.sv]
// Controller state machine that sequences frame setup and per-pixel address steps.
module ccrag_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_restart,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ccrag_pkg::dp_stat_type  stat,
   output ccrag_pkg::dp_op_type    op
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHK_OUT,
      S_CHK_RAW,
      S_CHK_END,
      S_DECIDE,
      S_ERR_OUT,
      S_DIV_W,
      S_WAIT_W,
      S_DIV_H,
      S_WAIT_H,
      S_SCALE,
      S_CROP_X,
      S_CROP_Y,
      S_START,
      S_PIX_X,
      S_PIX_Y,
      S_PIX_S,
      S_PIX_SR,
      S_PIX_P,
      S_PIX_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      op           = ccrag_pkg::OP_NOP;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_restart || !stat.running) ? S_CHK_OUT : S_PIX_X;
            end
         end
         S_CHK_OUT: begin
            op       = ccrag_pkg::OP_CHK_OUT;
            state_in = S_CHK_RAW;
         end
         S_CHK_RAW: begin
            op       = ccrag_pkg::OP_CHK_RAW;
            state_in = S_CHK_END;
         end
         S_CHK_END: begin
            op       = ccrag_pkg::OP_CHK_END;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = (stat.status == ccrag_pkg::STATUS_OK) ? S_DIV_W : S_ERR_OUT;
         end
         S_ERR_OUT: begin
            if (slot_free) begin
               op           = ccrag_pkg::OP_ERR_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DIV_W: begin
            op       = ccrag_pkg::OP_DIV_W;
            state_in = S_WAIT_W;
         end
         S_WAIT_W: begin
            if (!stat.div_busy) begin
               state_in = S_DIV_H;
            end
         end
         S_DIV_H: begin
            op       = ccrag_pkg::OP_DIV_H;
            state_in = S_WAIT_H;
         end
         S_WAIT_H: begin
            if (!stat.div_busy) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            op       = ccrag_pkg::OP_SCALE;
            state_in = S_CROP_X;
         end
         S_CROP_X: begin
            op       = ccrag_pkg::OP_CROP_X;
            state_in = S_CROP_Y;
         end
         S_CROP_Y: begin
            op       = ccrag_pkg::OP_CROP_Y;
            state_in = S_START;
         end
         S_START: begin
            op       = ccrag_pkg::OP_FRAME_START;
            state_in = S_PIX_X;
         end
         S_PIX_X: begin
            op       = ccrag_pkg::OP_PIX_X;
            state_in = S_PIX_Y;
         end
         S_PIX_Y: begin
            op       = ccrag_pkg::OP_PIX_Y;
            state_in = S_PIX_S;
         end
         S_PIX_S: begin
            op       = ccrag_pkg::OP_PIX_S;
            state_in = S_PIX_SR;
         end
         S_PIX_SR: begin
            op       = ccrag_pkg::OP_PIX_SR;
            state_in = S_PIX_P;
         end
         S_PIX_P: begin
            op       = ccrag_pkg::OP_PIX_P;
            state_in = S_PIX_OUT;
         end
         S_PIX_OUT: begin
            if (slot_free) begin
               op           = ccrag_pkg::OP_PIX_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/center_crop_resize_address_gen_core.sv]
// Top level of the center-crop nearest-neighbor resize read-address generator.
// Each request transfer yields one response transfer holding the three source byte
// addresses of the next packed output pixel, its destination offset and a last flag,
// or an error status with zero addresses and offset. One item is processed at a time.
// A pixel of a running frame passes through steps that share one 27x11 multiplier,
// then an output step that waits for a free response slot. The first pixel of a
// frame (restart, or any request with no frame running) first goes through the
// configuration check and the two scale ratios, which use a serial divider at one
// quotient bit per cycle; a configuration error skips the divider. The request side
// is ready again while an earlier response still waits to be taken.
module center_crop_resize_address_gen_core #(
   parameter int unsigned MAX_DIM = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [ccrag_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ccrag_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ccrag_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ccrag_pkg::ADDR_W-1:0]         rsp_src_addr_byte0,
   output logic [ccrag_pkg::ADDR_W-1:0]         rsp_src_addr_byte1,
   output logic [ccrag_pkg::ADDR_W-1:0]         rsp_src_addr_byte2,
   output logic [ccrag_pkg::ADDR_W-1:0]         rsp_dst_offset,
   output logic                                 rsp_last
);

   ccrag_pkg::cfg_type     cfg_ff, cfg_in;
   ccrag_pkg::dp_op_type   op;
   ccrag_pkg::dp_stat_type stat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ccrag_pkg::REG_RAW_WIDTH:
               cfg_in.raw_width = csr_wdata[ccrag_pkg::DIM_W-1:0];
            ccrag_pkg::REG_RAW_HEIGHT:
               cfg_in.raw_height = csr_wdata[ccrag_pkg::DIM_W-1:0];
            ccrag_pkg::REG_RAW_CHANNELS:
               cfg_in.raw_channels = csr_wdata[ccrag_pkg::CHAN_W-1:0];
            ccrag_pkg::REG_RAW_SIZE:
               cfg_in.raw_size_bytes = csr_wdata[ccrag_pkg::ADDR_W-1:0];
            ccrag_pkg::REG_OUT_WIDTH:
               cfg_in.out_width = csr_wdata[ccrag_pkg::DIM_W-1:0];
            ccrag_pkg::REG_OUT_HEIGHT:
               cfg_in.out_height = csr_wdata[ccrag_pkg::DIM_W-1:0];
            ccrag_pkg::REG_OUT_CAPACITY:
               cfg_in.out_capacity_bytes = csr_wdata[ccrag_pkg::ADDR_W-1:0];
            ccrag_pkg::REG_BGR_ORDER:
               cfg_in.bgr_order = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ccrag_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccrag_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .stat        (stat),
      .op          (op)
   );

   ccrag_dpath #(
      .MAX_DIM (MAX_DIM)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .op                 (op),
      .stat               (stat),
      .rsp_status         (rsp_status),
      .rsp_src_addr_byte0 (rsp_src_addr_byte0),
      .rsp_src_addr_byte1 (rsp_src_addr_byte1),
      .rsp_src_addr_byte2 (rsp_src_addr_byte2),
      .rsp_dst_offset     (rsp_dst_offset),
      .rsp_last           (rsp_last)
   );

`ifndef SYNTHESIS
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ccrag_pkg::STATUS_OK |-> rsp_last && rsp_dst_offset == '0)
      else $error("error response without last flag or with nonzero offset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is still in work");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ccrag_pkg::STATUS_RAW_SMALL)
      else $error("response status code out of range");
`endif

endmodule
